// ===== hdl/wtsp_pkg.sv =====
//------------------------------------------------------------------------------
// wtsp_pkg
// Shared types and constants of the world-to-screen projection unit.
//------------------------------------------------------------------------------
`default_nettype none

package wtsp_pkg;

    localparam int NUM_REGS  = 8;
    localparam int ADDR_W    = 6;
    localparam int CLIP_W    = 52;
    localparam int PROD_W    = 64;
    localparam int NUM_W     = 67;
    localparam int DEN_W     = 53;
    localparam int QUO_W     = 65;

    localparam logic [63:0] RESET_REG0 = 64'h0001000000010000;
    localparam logic [63:0] RESET_REG2 = 64'h0001000000000000;
    localparam logic [63:0] RESET_REG5 = 64'h0000000000010000;
    localparam logic [63:0] RESET_REG7 = 64'h0001000000000000;

    typedef logic signed [31:0]        q16_t;
    typedef logic signed [CLIP_W-1:0]  clip_t;
    typedef logic        [NUM_W-1:0]   num_t;
    typedef logic        [DEN_W-1:0]   den_t;
    typedef logic        [QUO_W-1:0]   quo_t;

    // One cell's hand-off: operands and partial results of three divisions.
    typedef struct packed {
        logic        vis;
        logic        neg_x;
        logic        neg_y;
        logic        neg_d;
        den_t        den_w;
        num_t        rem_x;
        num_t        rem_y;
        num_t        rem_d;
        quo_t        quo_x;
        quo_t        quo_y;
        quo_t        quo_d;
        num_t        num_x;
        num_t        num_y;
        num_t        num_d;
    } div_lane_t;

endpackage : wtsp_pkg

`default_nettype wire

// ===== hdl/wtsp_div_cell.sv =====
//------------------------------------------------------------------------------
// wtsp_div_cell
// One cell of the divider chain: retires BITS quotient bits of three
// restoring divisions sharing one divisor, then hands the lane on.
//------------------------------------------------------------------------------
`default_nettype none

module wtsp_div_cell #(
    parameter int BITS = 1
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  en,
    input  wire                  in_valid,
    input  wtsp_pkg::div_lane_t  in_lane,
    output logic                 out_valid,
    output wtsp_pkg::div_lane_t  out_lane
);
    import wtsp_pkg::*;

    div_lane_t lane_next;
    div_lane_t lane_reg;
    logic      valid_reg;

    function automatic void step(input num_t r, input num_t n, input quo_t q,
                                 input den_t d, output num_t ro, output num_t no,
                                 output quo_t qo);
        logic [NUM_W:0] t;
        t  = {r, n[NUM_W-1]};
        no = {n[NUM_W-2:0], 1'b0};
        if (t >= {{(NUM_W+1-DEN_W){1'b0}}, d}) begin
            t  = t - {{(NUM_W+1-DEN_W){1'b0}}, d};
            qo = {q[QUO_W-2:0], 1'b1};
        end else begin
            qo = {q[QUO_W-2:0], 1'b0};
        end
        ro = t[NUM_W-1:0];
    endfunction

    always_comb begin
        lane_next = in_lane;
        for (int i = 0; i < BITS; i++) begin
            step(lane_next.rem_x, lane_next.num_x, lane_next.quo_x, lane_next.den_w,
                 lane_next.rem_x, lane_next.num_x, lane_next.quo_x);
            step(lane_next.rem_y, lane_next.num_y, lane_next.quo_y, lane_next.den_w,
                 lane_next.rem_y, lane_next.num_y, lane_next.quo_y);
            step(lane_next.rem_d, lane_next.num_d, lane_next.quo_d, lane_next.den_w,
                 lane_next.rem_d, lane_next.num_d, lane_next.quo_d);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
        if (en) begin
            lane_reg <= lane_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_lane  = lane_reg;

endmodule : wtsp_div_cell

`default_nettype wire

// ===== hdl/world_to_screen_projection_unit.sv =====
//------------------------------------------------------------------------------
// world_to_screen_projection_unit
// Projects world points through a 4x4 view matrix to viewport pixels and depth.
//------------------------------------------------------------------------------
// Accepts one point per clock while the pipe advances. A first register stage
// holds the twelve 32x32 products, the next sums each matrix row, the next forms the
// numerators, then a chain of 67 divider cells (one quotient bit each) does
// the three divisions by w, and a last stage saturates into the output register.
// The whole pipe advances whenever the output register is empty or taken.
`default_nettype none

module world_to_screen_projection_unit #(
    parameter int VIEW_WIDTH  = 800,
    parameter int VIEW_HEIGHT = 600
) (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        psel,
    input  wire                        penable,
    input  wire                        pwrite,
    input  wire  [wtsp_pkg::ADDR_W-1:0] paddr,
    input  wire  [63:0]                pwdata,
    output logic [63:0]                prdata,
    output logic                       pready,
    input  wire                        s_valid,
    output logic                       s_ready,
    input  wire  signed [31:0]         s_world_x,
    input  wire  signed [31:0]         s_world_y,
    input  wire  signed [31:0]         s_world_z,
    output logic                       m_valid,
    input  wire                        m_ready,
    output logic                       m_visible,
    output logic signed [15:0]         m_screen_x,
    output logic signed [15:0]         m_screen_y,
    output logic signed [31:0]         m_depth
);
    import wtsp_pkg::*;

    localparam int CELLS = NUM_W;

    logic [63:0] mat_reg [NUM_REGS];
    logic [2:0]  ridx;
    assign ridx   = paddr[5:3];
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mat_reg[0] <= RESET_REG0;
            mat_reg[1] <= '0;
            mat_reg[2] <= RESET_REG2;
            mat_reg[3] <= '0;
            mat_reg[4] <= '0;
            mat_reg[5] <= RESET_REG5;
            mat_reg[6] <= '0;
            mat_reg[7] <= RESET_REG7;
        end else if (psel && penable && pwrite && pready) begin
            mat_reg[ridx] <= pwdata;
        end
    end
    assign prdata = mat_reg[ridx];

    function automatic q16_t ent(input logic [3:0] k);
        return k[0] ? q16_t'(mat_reg[k[3:1]][63:32]) : q16_t'(mat_reg[k[3:1]][31:0]);
    endfunction

    logic en;
    logic m_valid_reg;
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // stage 1: products
    logic               v1_reg;
    logic signed [63:0] prod_reg [4][3];
    q16_t               trans_reg [4];
    always_ff @(posedge aclk) begin
        if (!aresetn) v1_reg <= 1'b0;
        else if (en) v1_reg <= s_valid;
        if (en) begin
            for (int r = 0; r < 4; r++) begin
                prod_reg[r][0] <= 64'(s_world_x) * 64'(ent(4'(r)));
                prod_reg[r][1] <= 64'(s_world_y) * 64'(ent(4'(r + 4)));
                prod_reg[r][2] <= 64'(s_world_z) * 64'(ent(4'(r + 8)));
                trans_reg[r]   <= ent(4'(r + 12));
            end
        end
    end

    // stage 2: clip values, floor of the exact sum
    logic  v2_reg;
    clip_t clip_reg [4];
    always_ff @(posedge aclk) begin
        if (!aresetn) v2_reg <= 1'b0;
        else if (en) v2_reg <= v1_reg;
        if (en) begin
            for (int r = 0; r < 4; r++) begin
                clip_reg[r] <= CLIP_W'((66'(prod_reg[r][0]) + 66'(prod_reg[r][1])
                               + 66'(prod_reg[r][2])) >>> 16) + CLIP_W'(trans_reg[r]);
            end
        end
    end

    // stage 3: numerators and lane setup
    logic signed [67:0] nx, ny, nd;
    logic               vis;
    div_lane_t          lane0;
    always_comb begin
        vis = !clip_reg[3][CLIP_W-1] && clip_reg[3] != '0;
        nx  = (68'(clip_reg[0]) + 68'(clip_reg[3])) * 68'(VIEW_WIDTH);
        ny  = (68'(clip_reg[3]) - 68'(clip_reg[1])) * 68'(VIEW_HEIGHT);
        nd  = 68'(clip_reg[2]) <<< 16;
        lane0       = '0;
        lane0.vis   = vis;
        lane0.neg_x = nx[67];
        lane0.neg_y = ny[67];
        lane0.neg_d = nd[67];
        lane0.den_w = vis ? DEN_W'(clip_reg[3]) : DEN_W'(1);
        lane0.num_x = NUM_W'(nx[67] ? -nx : nx);
        lane0.num_y = NUM_W'(ny[67] ? -ny : ny);
        lane0.num_d = NUM_W'(nd[67] ? -nd : nd);
    end

    logic      v3_reg;
    div_lane_t l3_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v3_reg <= 1'b0;
        else if (en) v3_reg <= v2_reg;
        if (en) l3_reg <= lane0;
    end

    // x and y divide by 2w: quotient of n/w, then shift right by one
    logic      cv   [CELLS+1];
    div_lane_t cl   [CELLS+1];
    assign cv[0] = v3_reg;
    assign cl[0] = l3_reg;
    for (genvar g = 0; g < CELLS; g++) begin : g_cell
        wtsp_div_cell #(.BITS(1)) u_cell (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .in_valid(cv[g]), .in_lane(cl[g]),
            .out_valid(cv[g+1]), .out_lane(cl[g+1])
        );
    end

    div_lane_t lf;
    quo_t      qx, qy;
    logic      sat_x, sat_y, sat_d;
    logic signed [15:0] sx, sy;
    logic signed [31:0] dd;
    always_comb begin
        lf    = cl[CELLS];
        qx    = lf.quo_x >> 1;
        qy    = lf.quo_y >> 1;
        sat_x = qx > quo_t'(lf.neg_x ? 32768 : 32767);
        sat_y = qy > quo_t'(lf.neg_y ? 32768 : 32767);
        sat_d = lf.quo_d >= quo_t'(64'h80000000);
        sx = sat_x ? (lf.neg_x ? -16'sd32768 : 16'sd32767)
                   : (lf.neg_x ? -16'(qx) : 16'(qx));
        sy = sat_y ? (lf.neg_y ? -16'sd32768 : 16'sd32767)
                   : (lf.neg_y ? -16'(qy) : 16'(qy));
        dd = sat_d ? (lf.neg_d ? 32'sh80000000 : 32'sh7fffffff)
                   : (lf.neg_d ? -32'(lf.quo_d) : 32'(lf.quo_d));
        if (!lf.vis) begin
            sx = '0;
            sy = '0;
            dd = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) m_valid_reg <= 1'b0;
        else if (en) m_valid_reg <= cv[CELLS];
        if (en) begin
            m_visible  <= lf.vis;
            m_screen_x <= sx;
            m_screen_y <= sy;
            m_depth    <= dd;
        end
    end
    assign m_valid = m_valid_reg;

endmodule : world_to_screen_projection_unit

`default_nettype wire

// ===== hdl/wtsp_checker.sv =====
//------------------------------------------------------------------------------
// wtsp_checker
// Port-level checks of the projection unit.
//------------------------------------------------------------------------------
`default_nettype none

module wtsp_checker (
    input wire               aclk,
    input wire               aresetn,
    input wire               pready,
    input wire               m_valid,
    input wire               m_ready,
    input wire               m_visible,
    input wire signed [15:0] m_screen_x,
    input wire signed [31:0] m_depth
);
    a_pready: assert property (@(posedge aclk) disable iff (!aresetn) pready)
        else $error("pready low");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_depth))
        else $error("result beat dropped");
    a_hidden_x: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_visible |-> m_screen_x == 16'sd0)
        else $error("hidden point has screen x");
    a_hidden_d: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_visible |-> m_depth == 32'sd0)
        else $error("hidden point has depth");
endmodule : wtsp_checker

bind world_to_screen_projection_unit wtsp_checker u_wtsp_checker (
    .aclk(aclk), .aresetn(aresetn), .pready(pready), .m_valid(m_valid),
    .m_ready(m_ready), .m_visible(m_visible), .m_screen_x(m_screen_x),
    .m_depth(m_depth)
);

`default_nettype wire

// ===== tb/world_to_screen_projection_unit_tb.sv =====
//------------------------------------------------------------------------------
// world_to_screen_projection_unit_tb
// Self-checking bench for the world-to-screen projection unit: directed points
// under the reset matrix, then random points over several view matrices written
// through the register port, with random gaps and stalls on both channels.
//------------------------------------------------------------------------------
`default_nettype none

module world_to_screen_projection_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wtsp_pkg::*;

    localparam int  W_PIX   = 800;
    localparam int  H_PIX   = 600;
    localparam int  DRAIN   = 100;
    localparam int  N_PHASE = 6;
    localparam int  PER_PHASE = 160;
    localparam int  ONE = 32'h0001_0000;

    typedef struct {
        logic        vis;
        logic [15:0] sx;
        logic [15:0] sy;
        logic [31:0] depth;
    } screen_pt_t;

    typedef struct {
        logic [31:0] x, y, z;
        bit          typed;
        screen_pt_t  res;
    } point_row_t;

    logic                aclk;
    logic                aresetn;
    logic                psel, penable, pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [63:0]         pwdata;
    logic [63:0]         prdata;
    logic                pready;
    logic                s_valid, s_ready;
    logic signed [31:0]  s_world_x, s_world_y, s_world_z;
    logic                m_valid, m_ready;
    logic                m_visible;
    logic signed [15:0]  m_screen_x, m_screen_y;
    logic signed [31:0]  m_depth;

    logic [63:0]  view_regs [NUM_REGS];
    screen_pt_t   pending_pts [$];
    int           mismatches;
    bit           hold_off;

    world_to_screen_projection_unit #(.VIEW_WIDTH(W_PIX), .VIEW_HEIGHT(H_PIX)) dut (.*);

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #10ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    //--------------------------------------------------------------------------
    // projection predictor
    //--------------------------------------------------------------------------
    function automatic logic signed [95:0] matrix_entry(int k);
        logic [63:0] r;
        r = view_regs[k >> 1];
        return (k & 1) ? $signed(r[63:32]) : $signed(r[31:0]);
    endfunction

    // exact row sum, floored once to Q16.16, plus translation
    function automatic logic signed [95:0] clip_row(logic signed [95:0] x, y, z, int k0);
        logic signed [95:0] acc;
        acc = x * matrix_entry(k0) + y * matrix_entry(k0 + 4) + z * matrix_entry(k0 + 8);
        return (acc >>> 16) + matrix_entry(k0 + 12);
    endfunction

    function automatic logic [15:0] clamp16(logic signed [95:0] v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic screen_pt_t project_point(logic [31:0] wx, wy, wz);
        screen_pt_t p;
        logic signed [95:0] x, y, z, cx, cy, cz, cw, mag, quo;
        bit neg;
        x = $signed(wx);
        y = $signed(wy);
        z = $signed(wz);
        cx = clip_row(x, y, z, 0);
        cy = clip_row(x, y, z, 1);
        cz = clip_row(x, y, z, 2);
        cw = clip_row(x, y, z, 3);
        p = '{1'b0, 16'd0, 16'd0, 32'd0};
        if (cw <= 0) return p;
        p.vis = 1'b1;
        p.sx  = clamp16(((cx + cw) * W_PIX) / (2 * cw));
        p.sy  = clamp16(((cw - cy) * H_PIX) / (2 * cw));
        neg = cz < 0;
        mag = neg ? -cz : cz;
        if (mag / cw >= 32768) begin
            p.depth = neg ? 32'h8000_0000 : 32'h7fff_ffff;
        end else begin
            quo = (mag <<< 16) / cw;
            if (neg) quo = -quo;
            p.depth = quo[31:0];
        end
        return p;
    endfunction

    //--------------------------------------------------------------------------
    // register port
    //--------------------------------------------------------------------------
    task automatic write_matrix_reg(int idx, logic [63:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(8 * idx);
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        view_regs[idx] = val;
        @(posedge aclk);
    endtask

    // small signed Q16.16 value, |v| < 2^bits
    function automatic logic [31:0] small_q16(int bits);
        logic [31:0] v;
        v = $urandom_range((1 << bits) - 1, 0);
        return $urandom_range(1, 0) ? -v : v;
    endfunction

    task automatic load_matrix(int phase);
        logic [31:0] e [16];
        for (int k = 0; k < 16; k++) begin
            case (phase)
                1: e[k] = 32'h0;
                2: e[k] = 32'hffff_ffff;
                3: e[k] = (k % 2) ? 32'h8000_0000 : 32'h7fff_ffff;
                4: e[k] = $urandom();
                default: e[k] = small_q16(18);
            endcase
        end
        // keep w mostly positive on the small random views (phase 5 on) so points project
        if (phase >= 5) begin
            e[3]  = small_q16(12);
            e[7]  = small_q16(12);
            e[11] = $urandom_range(ONE, 0);
            e[15] = $urandom_range(8 * ONE, ONE / 4);
        end
        for (int r = 0; r < NUM_REGS; r++)
            write_matrix_reg(r, {e[2 * r + 1], e[2 * r]});
    endtask

    //--------------------------------------------------------------------------
    // input side
    //--------------------------------------------------------------------------
    task automatic send_point(logic [31:0] x, y, z, bit typed, screen_pt_t res);
        int gap;
        gap = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 5)
            : ($urandom_range(2, 0) == 0 ? $urandom_range(3, 1) : 0);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_world_x <= x;
        s_world_y <= y;
        s_world_z <= z;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (typed)
            pending_pts.push_back(res);
        else
            pending_pts.push_back(project_point(x, y, z));
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_pts.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3, 0))
            0: return $urandom();
            1: return small_q16(10);
            default: return small_q16(20);
        endcase
    endfunction

    //--------------------------------------------------------------------------
    // output side
    //--------------------------------------------------------------------------
    initial begin
        int run;
        m_ready <= 1'b0;
        forever begin
            if (hold_off) begin
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
                hold_off = 1'b0;
            end
            run = ($urandom_range(19, 0) == 0) ? $urandom_range(60, 10) : $urandom_range(4, 1);
            m_ready <= ($urandom_range(3, 0) != 0);
            repeat (run) @(posedge aclk);
        end
    end

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("[%0t] %s: got %h, want %h", $realtime, field, got, want);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        screen_pt_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_pts.size() == 0) begin
                report_mismatch("unexpected beat", 32'd0, 32'd0);
            end else begin
                want = pending_pts.pop_front();
                if (m_visible !== want.vis)
                    report_mismatch("visible", {31'd0, m_visible}, {31'd0, want.vis});
                if (m_screen_x !== want.sx)
                    report_mismatch("screen_x", {16'd0, m_screen_x}, {16'd0, want.sx});
                if (m_screen_y !== want.sy)
                    report_mismatch("screen_y", {16'd0, m_screen_y}, {16'd0, want.sy});
                if (m_depth !== want.depth) report_mismatch("depth", m_depth, want.depth);
            end
        end
    end

    //--------------------------------------------------------------------------
    // main sequence
    //--------------------------------------------------------------------------
    initial begin
        point_row_t rows [$];
        screen_pt_t none;
        none = '{1'b0, 16'd0, 16'd0, 32'd0};
        mismatches = 0;
        hold_off   = 1'b0;
        aresetn    <= 1'b0;
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        paddr <= '0; pwdata <= '0;
        s_valid <= 1'b0;
        s_world_x <= '0; s_world_y <= '0; s_world_z <= '0;
        view_regs = '{RESET_REG0, 64'd0, RESET_REG2, 64'd0,
                      64'd0, RESET_REG5, 64'd0, RESET_REG7};
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset view: cx = x, cy = x + y, cz = z, cw = 1.0
        rows = '{
            '{32'h0, 32'h0, 32'h0, 1, '{1'b1, 16'd400, 16'd300, 32'h0}},
            '{ONE, 32'h0, ONE / 2, 1, '{1'b1, 16'd800, 16'd0, 32'h8000}},
            '{-ONE, ONE, -ONE, 1, '{1'b1, 16'd0, 16'd300, 32'hffff_0000}},
            '{32'h7fff_ffff, 32'h0, 32'h7fff_ffff, 1,
              '{1'b1, 16'h7fff, 16'h8000, 32'h7fff_ffff}},
            '{32'h8000_0000, 32'h0, 32'h8000_0000, 1,
              '{1'b1, 16'h8000, 16'h7fff, 32'h8000_0000}},
            '{32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 0, none},
            '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001, 0, none},
            '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 0, none},
            '{32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 0, none},
            '{32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 0, none},
            '{32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 0, none},
            '{32'h0001_8000, 32'hfffe_8000, 32'h0000_4000, 0, none}
        };
        foreach (rows[i])
            send_point(rows[i].x, rows[i].y, rows[i].z, rows[i].typed, rows[i].res);
        wait_idle();

        // zero matrix: w is zero so every point is flagged off screen
        load_matrix(1);
        send_point(32'h7fff_ffff, 32'h8000_0000, 32'h1234_5678, 1, none);
        send_point(32'h0, 32'h0, 32'h0, 1, none);

        for (int ph = 2; ph < 2 + N_PHASE; ph++) begin
            wait_idle();
            load_matrix(ph);
            if (ph == 5) hold_off = 1'b1;
            for (int n = 0; n < PER_PHASE; n++)
                send_point(rand_coord(), rand_coord(), rand_coord(), 0, none);
        end

        wait_idle();
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule : world_to_screen_projection_unit_tb

`default_nettype wire

// ===== world_to_screen_projection_unit.f =====
hdl/wtsp_pkg.sv
hdl/wtsp_div_cell.sv
hdl/world_to_screen_projection_unit.sv
hdl/wtsp_checker.sv
tb/world_to_screen_projection_unit_tb.sv
